[rtl/core/isds_pkg.sv]
// ----------------------------------------------------------------------------
// isds_pkg
// Shared constants and types of the principal stress pipeline.
// ----------------------------------------------------------------------------
package isds_pkg;

  localparam int STRETCH_FRAC_BITS = 28;

  localparam int STRETCH_W = 31;
  localparam int FIELD_W   = 32;
  localparam int STRESS_W  = 64;
  localparam int TOTAL_W   = 129;

  localparam int ONE_SH   = 3 * STRETCH_FRAC_BITS;
  localparam int D_SH     = 3 * STRETCH_FRAC_BITS - 31;
  localparam int C_SH     = 2 * STRETCH_FRAC_BITS;
  localparam int T3_SH    = 30 - STRETCH_FRAC_BITS;
  localparam int OUT_SH   = 3 * STRETCH_FRAC_BITS - 16;

  // 864 = 32 * 27
  localparam int        DIV_PRE_SH = 5;
  localparam int        DIV_STEPS  = 4;
  localparam int        DIV27_SH   = 42;
  localparam logic [37:0] DIV27_M  = 38'd162890611522;
  localparam logic [5:0]  DIV27_D  = 6'd27;

  localparam int          CFG_IDX_W   = 2;
  localparam int          CFG_DATA_W  = 31;
  localparam logic [CFG_IDX_W-1:0] REG_INV_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_EN = 2'd1;
  localparam logic [STRETCH_W-1:0] THR_RESET   = 31'd26843546;

  localparam int PIPE_DEPTH = 18;

  typedef struct packed {
    logic [STRETCH_W-1:0] si;
    logic [STRETCH_W-1:0] sj;
    logic [STRETCH_W-1:0] sk;
    logic [FIELD_W-1:0]   lam;
    logic [FIELD_W-1:0]   mu;
  } lane_in_t;

  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
  } vol_t;

  typedef struct packed {
    logic signed [STRESS_W-1:0] stress;
    logic                       sat;
  } lane_out_t;

endpackage

[rtl/core/isds_if.sv]
// ----------------------------------------------------------------------------
// isds_if
// Request and result channels of the principal stress pipeline.
// ----------------------------------------------------------------------------
interface isds_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] stretch_a;
  logic [31:0] stretch_b;
  logic [31:0] stretch_c;
  logic [31:0] lame_first;
  logic [31:0] lame_shear;
  logic [31:0] compression_factor;

  modport source (output valid, stretch_a, stretch_b, stretch_c, lame_first, lame_shear,
                  compression_factor, input ready);
  modport sink (input valid, stretch_a, stretch_b, stretch_c, lame_first, lame_shear,
                compression_factor, output ready);
endinterface

interface isds_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] stress_a;
  logic [63:0] stress_b;
  logic [63:0] stress_c;
  logic        saturated;

  modport source (output valid, stress_a, stress_b, stress_c, saturated, input ready);
  modport sink (input valid, stress_a, stress_b, stress_c, saturated, output ready);
endinterface

[rtl/core/isds_lane.sv]
// ----------------------------------------------------------------------------
// isds_lane
// One principal direction: polynomial terms, compression term, divide by 864,
// final scaling and saturation. Stages 2 to 18 of the pipeline.
// ----------------------------------------------------------------------------
module isds_lane (
  input  logic                clk,
  input  logic                en,
  input  isds_pkg::lane_in_t  lin,
  input  isds_pkg::vol_t      vol,
  input  logic [61:0]         kd,
  output isds_pkg::lane_out_t lout
);

  // stage 2
  logic [62:0] p1_2, sm2;
  logic [61:0] sjk2, sq2;
  logic [30:0] si2;
  logic [31:0] mu2;
  // stage 3
  logic [62:0] cl3, p1_3, sm3;
  logic [60:0] ch3;
  logic [61:0] sjk3;
  logic [31:0] mu3;
  // stage 4
  logic [92:0] cube4;
  logic [63:0] a00, a01;
  logic [62:0] a10, a11;
  logic        neg4;
  logic [62:0] sm4;
  logic [61:0] sjk4;
  logic [31:0] mu4;
  // stage 5
  logic [126:0] a5;
  logic [63:0]  bp0, bp1;
  logic [60:0]  bp2;
  logic         neg5;
  logic [62:0]  sm5;
  logic [61:0]  sjk5;
  // stage 6
  logic signed [128:0] a6;
  logic [124:0]        b6;
  logic [62:0]         sm6;
  logic [61:0]         sjk6;
  // stage 7
  logic signed [128:0] base7;
  logic [63:0]         t00;
  logic [61:0]         t01, t10;
  logic [59:0]         t11;
  // stage 8
  logic signed [128:0] base8;
  logic [123:0]        t8;
  // divider
  logic [36:0]         dv_cur  [isds_pkg::DIV_STEPS];
  logic [31:0]         dv_qe   [isds_pkg::DIV_STEPS];
  logic [127:0]        dv_xa   [isds_pkg::DIV_STEPS];
  logic [127:0]        dv_qa   [isds_pkg::DIV_STEPS];
  logic signed [128:0] dv_ba   [isds_pkg::DIV_STEPS];
  logic [4:0]          dv_rem  [isds_pkg::DIV_STEPS];
  logic [127:0]        dv_xb   [isds_pkg::DIV_STEPS];
  logic [127:0]        dv_qb   [isds_pkg::DIV_STEPS];
  logic signed [128:0] dv_bb   [isds_pkg::DIV_STEPS];
  // stage 17
  logic signed [128:0] total17;

  logic signed [128:0] aneg;
  logic [128:0]        b_ext, c_ext, q_ext;
  logic signed [128:0] rsh;
  logic                ovf;

  always_comb begin
    aneg  = neg5 ? -$signed({2'b00, a5}) : $signed({2'b00, a5});
    b_ext = 129'(b6);
    c_ext = 129'(sm6) << isds_pkg::C_SH;
    q_ext = 129'(dv_qb[isds_pkg::DIV_STEPS-1] >> isds_pkg::T3_SH);
    rsh   = total17 >>> isds_pkg::OUT_SH;
    ovf   = rsh[128:63] != {66{rsh[63]}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_2 <= lin.si * lin.lam;
      sm2  <= lin.si * lin.mu;
      sjk2 <= lin.sj * lin.sk;
      sq2  <= lin.si * lin.si;
      si2  <= lin.si;
      mu2  <= lin.mu;

      cl3  <= sq2[31:0] * si2;
      ch3  <= sq2[61:32] * si2;
      p1_3 <= p1_2;
      sm3  <= sm2;
      sjk3 <= sjk2;
      mu3  <= mu2;

      cube4 <= 93'(cl3) + {ch3, 32'd0};
      a00   <= p1_3[31:0] * vol.mag[31:0];
      a01   <= p1_3[31:0] * vol.mag[63:32];
      a10   <= p1_3[62:32] * vol.mag[31:0];
      a11   <= p1_3[62:32] * vol.mag[63:32];
      neg4  <= vol.neg;
      sm4   <= sm3;
      sjk4  <= sjk3;
      mu4   <= mu3;

      a5   <= 127'(a00) + (127'(a01) << 32) + (127'(a10) << 32) + (127'(a11) << 64);
      bp0  <= cube4[31:0] * mu4;
      bp1  <= cube4[63:32] * mu4;
      bp2  <= cube4[92:64] * mu4;
      neg5 <= neg4;
      sm5  <= sm4;
      sjk5 <= sjk4;

      a6   <= aneg >>> 1;
      b6   <= 125'(bp0) + (125'(bp1) << 32) + (125'(bp2) << 64);
      sm6  <= sm5;
      sjk6 <= sjk5;

      base7 <= a6 + $signed(b_ext) - $signed(c_ext);
      t00   <= kd[31:0] * sjk6[31:0];
      t01   <= kd[31:0] * sjk6[61:32];
      t10   <= kd[61:32] * sjk6[31:0];
      t11   <= kd[61:32] * sjk6[61:32];

      base8 <= base7;
      t8    <= 124'(t00) + (124'(t01) << 32) + (124'(t10) << 32) + (124'(t11) << 64);
    end
  end

  // long division by 27, one 32-bit limb per step, two stages per step
  for (genvar n = 0; n < isds_pkg::DIV_STEPS; n++) begin : g_div
    logic [4:0]   rem_in;
    logic [127:0] x_in, q_in;
    logic signed [128:0] b_in;
    logic [36:0]  cur;
    logic [74:0]  prod;
    logic [37:0]  rr;
    logic [37:0]  qd;

    if (n == 0) begin : g_first
      always_comb begin
        rem_in = 5'd0;
        x_in   = 128'(t8 >> isds_pkg::DIV_PRE_SH);
        q_in   = 128'd0;
        b_in   = base8;
      end
    end else begin : g_next
      always_comb begin
        rem_in = dv_rem[n-1];
        x_in   = dv_xb[n-1];
        q_in   = dv_qb[n-1];
        b_in   = dv_bb[n-1];
      end
    end

    always_comb begin
      cur  = {rem_in, x_in[127:96]};
      prod = 75'(cur) * 75'(isds_pkg::DIV27_M);
      qd   = 38'(dv_qe[n]) * 38'(isds_pkg::DIV27_D);
      rr   = 38'(dv_cur[n]) - qd;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_cur[n] <= cur;
        dv_qe[n]  <= prod[isds_pkg::DIV27_SH +: 32];
        dv_xa[n]  <= {x_in[95:0], 32'd0};
        dv_qa[n]  <= q_in;
        dv_ba[n]  <= b_in;

        if (rr >= 38'(isds_pkg::DIV27_D)) begin
          dv_rem[n] <= 5'(rr - 38'(isds_pkg::DIV27_D));
          dv_qb[n]  <= {dv_qa[n][95:0], dv_qe[n] + 32'd1};
        end else begin
          dv_rem[n] <= rr[4:0];
          dv_qb[n]  <= {dv_qa[n][95:0], dv_qe[n]};
        end
        dv_xb[n] <= dv_xa[n];
        dv_bb[n] <= dv_ba[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total17 <= dv_bb[isds_pkg::DIV_STEPS-1] - $signed(q_ext);
      lout.sat <= ovf;
      if (ovf) begin
        lout.stress <= rsh[128] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        lout.stress <= rsh[63:0];
      end
    end
  end

endmodule

[rtl/core/invertible_stvk_diagonal_stress.sv]
// ----------------------------------------------------------------------------
// invertible_stvk_diagonal_stress
// Diagonal first Piola stress of an invertible StVK element: shared front for
// clamping, invariants and the volume term, three lanes, merging output stage.
//
//   channel   dir  handshake     payload
//   item_in   in   valid/ready   stretch_a..c, lame_first, lame_shear,
//                                compression_factor
//   item_out  out  valid/ready   stress_a..c, saturated
//   cfg       in   cfg_we        cfg_index, cfg_data
//
// One request per cycle while the output register is empty or taken.
// Pipeline depth is set by the multiplier chains and the four-step divide by 27.
// The whole pipeline advances when the output register is empty or taken.
// Synchronous reset clears valid bits and loads the config registers only; no clearing pass.
// ----------------------------------------------------------------------------
module invertible_stvk_diagonal_stress (
  input  logic                             clk,
  input  logic                             rst,
  isds_in_if.sink                          item_in,
  isds_out_if.source                       item_out,
  input  logic                             cfg_we,
  input  logic [isds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isds_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [30:0] thr;
  logic        comp_en;
  logic        en;
  logic [isds_pkg::PIPE_DEPTH:1] vld;

  logic [30:0] s1 [3];
  logic [31:0] lam1, mu1, k1;
  logic [61:0] sq2 [3];
  logic [61:0] s01_2;
  logic [30:0] s2_2;
  logic [31:0] k2, k3, k4, k5;
  logic [62:0] jlo3;
  logic [60:0] jhi3;
  isds_pkg::vol_t vol3;
  logic        comp4, comp5, comp6;
  logic [31:0] d31_4;
  logic [30:0] dd5;
  logic [61:0] kd6;

  logic [63:0] ic;
  logic [63:0] three;
  logic [92:0] jv;
  logic [92:0] one;
  logic [92:0] dv;
  logic [63:0] dsq;
  logic [31:0] sin [3];

  isds_pkg::lane_in_t  lin  [3];
  isds_pkg::lane_out_t lout [3];

  assign en = !item_out.valid || item_out.ready;
  assign item_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr     <= isds_pkg::THR_RESET;
      comp_en <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        isds_pkg::REG_INV_THR: thr     <= cfg_data[30:0];
        isds_pkg::REG_COMP_EN: comp_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sin[0] = item_in.stretch_a;
    sin[1] = item_in.stretch_b;
    sin[2] = item_in.stretch_c;
    ic     = 64'(sq2[0]) + 64'(sq2[1]) + 64'(sq2[2]);
    three  = 64'(3) << isds_pkg::C_SH;
    jv     = 93'(jlo3) + {jhi3, 32'd0};
    one    = 93'(1) << isds_pkg::ONE_SH;
    dv     = one - jv;
    dsq    = d31_4 * d31_4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[isds_pkg::PIPE_DEPTH-1:1], item_in.valid};
    end
  end

  // shared front
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1[i] <= (sin[i][31] || sin[i][30:0] < thr) ? thr : sin[i][30:0];
        sq2[i] <= s1[i] * s1[i];
      end
      lam1 <= item_in.lame_first;
      mu1  <= item_in.lame_shear;
      k1   <= item_in.compression_factor;

      s01_2 <= s1[0] * s1[1];
      s2_2  <= s1[2];
      k2    <= k1;

      vol3.neg <= ic < three;
      vol3.mag <= (ic < three) ? three - ic : ic - three;
      jlo3     <= s01_2[31:0] * s2_2;
      jhi3     <= s01_2[61:32] * s2_2;
      k3       <= k2;

      // zero volume ratio gives a deficit of exactly one
      comp4 <= comp_en && (jv < one);
      d31_4 <= (comp_en && (jv < one)) ? 32'(dv >> isds_pkg::D_SH) : 32'd0;
      k4    <= k3;

      dd5   <= dsq[62:32];
      comp5 <= comp4;
      k5    <= k4;

      kd6   <= comp5 ? 62'(64'(k5) * 64'(dd5)) : 62'd0;
      comp6 <= comp5;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    always_comb begin
      lin[i].si  = s1[i];
      lin[i].sj  = s1[(i + 1) % 3];
      lin[i].sk  = s1[(i + 2) % 3];
      lin[i].lam = lam1;
      lin[i].mu  = mu1;
    end

    isds_lane u_lane (
      .clk  (clk),
      .en   (en),
      .lin  (lin[i]),
      .vol  (vol3),
      .kd   (kd6),
      .lout (lout[i])
    );
  end

  // merge
  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (en) begin
      item_out.valid <= vld[isds_pkg::PIPE_DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_out.stress_a  <= lout[0].stress;
      item_out.stress_b  <= lout[1].stress;
      item_out.stress_c  <= lout[2].stress;
      item_out.saturated <= lout[0].sat | lout[1].sat | lout[2].sat;
    end
  end

  a_kd_off: assert property (@(posedge clk) disable iff (rst) !comp6 |-> kd6 == 62'd0)
    else $error("volume term active without compression");
  a_d_off: assert property (@(posedge clk) disable iff (rst) d31_4 != 32'd0 |-> comp4)
    else $error("volume deficit without compression");
  a_rst: assert property (@(posedge clk) rst |=> !item_out.valid && vld == '0)
    else $error("pipeline not empty after reset");

endmodule
